>>> hw/rtl/dpa_pkg.sv
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared constants, types and helper functions of the FP64 dot product unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dpa_pkg;

  localparam int unsigned LANES    = 4;
  localparam int unsigned FMUL_LAT = 4;
  localparam int unsigned FADD_LAT = 4;
  localparam int unsigned SQ_DEPTH = 4;
  localparam int unsigned PIPE_LAT = FMUL_LAT + 2 * FADD_LAT;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
  localparam logic [10:0] EXP_MAX   = 11'h7FF;
  localparam logic [12:0] EXP_OVF   = 13'd2047;

  typedef struct packed {
    logic        last;
    logic [63:0] sum;
  } blk_t;

  // Leading zero count of a 106-bit word; 106 when the word is zero.
  function automatic logic [6:0] lzc106(input logic [105:0] v);
    logic [6:0] n;
    logic       found;
    n     = 7'd106;
    found = 1'b0;
    for (int i = 105; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 7'(105 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Rounds a normalized mantissa (hidden bit at 55, guard at 2, round and
  // sticky below) to nearest even and packs it. A missing hidden bit means a
  // subnormal, and a rounding carry moves the value up one binade naturally.
  function automatic logic [63:0] round_pack(input logic s, input logic [12:0] e,
                                             input logic [55:0] m);
    logic [10:0] ef;
    logic        inc;
    logic [62:0] mag;
    inc = m[2] & (m[3] | m[1] | m[0]);
    ef  = m[55] ? e[10:0] : 11'd0;
    mag = {ef, m[54:3]} + {62'd0, inc};
    if (e >= EXP_OVF) begin
      return {s, EXP_MAX, 52'd0};
    end else begin
      return {s, mag};
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dpa_in_if.sv
// ----------------------------------------------------------------------------
// dpa_in_if
// Input channel: one block of four element pairs and the last-block flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpa_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] x_lane0;
  logic [63:0] x_lane1;
  logic [63:0] x_lane2;
  logic [63:0] x_lane3;
  logic [63:0] y_lane0;
  logic [63:0] y_lane1;
  logic [63:0] y_lane2;
  logic [63:0] y_lane3;
  logic        last_block;

  modport source (
    output valid, x_lane0, x_lane1, x_lane2, x_lane3,
    output y_lane0, y_lane1, y_lane2, y_lane3, last_block,
    input  ready
  );
  modport sink (
    input  valid, x_lane0, x_lane1, x_lane2, x_lane3,
    input  y_lane0, y_lane1, y_lane2, y_lane3, last_block,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/dpa_out_if.sv
// ----------------------------------------------------------------------------
// dpa_out_if
// Output channel: the finished dot product.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpa_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] dot_result;

  modport source (output valid, dot_result, input ready);
  modport sink   (input valid, dot_result, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dpa_fmul.sv
// ----------------------------------------------------------------------------
// dpa_fmul
// Four-stage binary64 multiplier, round to nearest even, full subnormals.
// ----------------------------------------------------------------------------
`default_nettype none

module dpa_fmul
  import dpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] p_o
);

  // Stage 1: unpack, classify, partial products.
  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic [52:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        nan_d, inf_d, zero_d;
  logic signed [13:0] e0_d;

  always_comb begin
    ea     = a_i[62:52];
    eb     = b_i[62:52];
    fa     = a_i[51:0];
    fb     = b_i[51:0];
    ma     = {|ea, fa};
    mb     = {|eb, fb};
    a_nan  = (ea == EXP_MAX) && (fa != 52'd0);
    b_nan  = (eb == EXP_MAX) && (fb != 52'd0);
    a_inf  = (ea == EXP_MAX) && (fa == 52'd0);
    b_inf  = (eb == EXP_MAX) && (fb == 52'd0);
    a_zero = (ea == 11'd0) && (fa == 52'd0);
    b_zero = (eb == 11'd0) && (fb == 52'd0);
    nan_d  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    inf_d  = a_inf | b_inf;
    zero_d = a_zero | b_zero;
    // Biased exponent for a product whose leading one sits at bit 105.
    e0_d   = 14'(((ea == 11'd0) ? 11'd1 : ea)) + 14'(((eb == 11'd0) ? 11'd1 : eb))
             - 14'sd1022;
  end

  logic               s1_nan_q, s1_inf_q, s1_zero_q, s1_sign_q;
  logic signed [13:0] s1_e0_q;
  logic [53:0]        s1_ll_q;
  logic [52:0]        s1_lh_q, s1_hl_q;
  logic [51:0]        s1_hh_q;

  always_ff @(posedge clk_i) begin
    s1_nan_q  <= nan_d;
    s1_inf_q  <= inf_d;
    s1_zero_q <= zero_d;
    s1_sign_q <= a_i[63] ^ b_i[63];
    s1_e0_q   <= e0_d;
    s1_ll_q   <= ma[26:0] * mb[26:0];
    s1_lh_q   <= ma[26:0] * mb[52:27];
    s1_hl_q   <= ma[52:27] * mb[26:0];
    s1_hh_q   <= ma[52:27] * mb[52:27];
  end

  // Stage 2: sum the partial products.
  logic               s2_nan_q, s2_inf_q, s2_zero_q, s2_sign_q;
  logic signed [13:0] s2_e0_q;
  logic [105:0]       s2_p_q;

  always_ff @(posedge clk_i) begin
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_zero_q <= s1_zero_q;
    s2_sign_q <= s1_sign_q;
    s2_e0_q   <= s1_e0_q;
    s2_p_q    <= {s1_hh_q, 54'd0} + (106'(s1_lh_q) << 27) + (106'(s1_hl_q) << 27)
                 + 106'(s1_ll_q);
  end

  // Stage 3: leading zero count and shift decision.
  logic [6:0]         lz;
  logic signed [13:0] diff, rsh;
  logic               left_d;
  logic [6:0]         sh_d, r_d;
  logic [12:0]        en_d;

  always_comb begin
    lz     = lzc106(s2_p_q);
    diff   = s2_e0_q - $signed({7'd0, lz});
    rsh    = 14'sd1 - s2_e0_q;
    left_d = 1'b1;
    sh_d   = 7'd0;
    r_d    = 7'd0;
    en_d   = 13'd1;
    if (diff > 14'sd0) begin
      sh_d = lz;
      en_d = 13'(diff);
    end else if (s2_e0_q > 14'sd0) begin
      // Stops at the subnormal exponent before the leading one is reached.
      sh_d = 7'(s2_e0_q - 14'sd1);
    end else begin
      left_d = 1'b0;
      r_d    = (rsh > 14'sd127) ? 7'd127 : rsh[6:0];
    end
  end

  logic         s3_nan_q, s3_inf_q, s3_zero_q, s3_sign_q, s3_left_q;
  logic [6:0]   s3_sh_q, s3_r_q;
  logic [12:0]  s3_en_q;
  logic [105:0] s3_p_q;

  always_ff @(posedge clk_i) begin
    s3_nan_q  <= s2_nan_q;
    s3_inf_q  <= s2_inf_q;
    s3_zero_q <= s2_zero_q;
    s3_sign_q <= s2_sign_q;
    s3_left_q <= left_d;
    s3_sh_q   <= sh_d;
    s3_r_q    <= r_d;
    s3_en_q   <= en_d;
    s3_p_q    <= s2_p_q;
  end

  // Stage 4: normalize, round and pack.
  logic [105:0] q, lost;
  logic [55:0]  m;
  logic [63:0]  res_d;

  always_comb begin
    if (s3_left_q) begin
      q    = s3_p_q << s3_sh_q;
      lost = 106'd0;
    end else begin
      q    = s3_p_q >> s3_r_q;
      lost = s3_p_q & ~({106{1'b1}} << s3_r_q);
    end
    m = {q[105:51], (|q[50:0]) | (|lost)};
    if (s3_nan_q) begin
      res_d = CANON_NAN;
    end else if (s3_inf_q) begin
      res_d = {s3_sign_q, EXP_MAX, 52'd0};
    end else if (s3_zero_q) begin
      res_d = {s3_sign_q, 63'd0};
    end else begin
      res_d = round_pack(s3_sign_q, s3_en_q, m);
    end
  end

  always_ff @(posedge clk_i) begin
    p_o <= res_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/dpa_fadd.sv
// ----------------------------------------------------------------------------
// dpa_fadd
// Four-stage binary64 adder, round to nearest even, full subnormals.
// ----------------------------------------------------------------------------
`default_nettype none

module dpa_fadd
  import dpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] s_o
);

  // Stage 1: classify, order by magnitude, align the smaller operand.
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [63:0] big, sml;
  logic [10:0] eb, es, d;
  logic [55:0] mb, ms, al;
  logic        st;

  always_comb begin
    a_nan = (a_i[62:52] == EXP_MAX) && (a_i[51:0] != 52'd0);
    b_nan = (b_i[62:52] == EXP_MAX) && (b_i[51:0] != 52'd0);
    a_inf = (a_i[62:52] == EXP_MAX) && (a_i[51:0] == 52'd0);
    b_inf = (b_i[62:52] == EXP_MAX) && (b_i[51:0] == 52'd0);
    swap  = b_i[62:0] > a_i[62:0];
    big   = swap ? b_i : a_i;
    sml   = swap ? a_i : b_i;
    eb    = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    es    = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    d     = eb - es;
    mb    = {|big[62:52], big[51:0], 3'd0};
    ms    = {|sml[62:52], sml[51:0], 3'd0};
    if (d > 11'd55) begin
      al = 56'd0;
      st = |ms;
    end else begin
      al = ms >> d[5:0];
      st = |(ms & ~({56{1'b1}} << d[5:0]));
    end
  end

  logic        s1_nan_q, s1_inf_q, s1_infs_q, s1_sign_q, s1_zs_q, s1_sub_q;
  logic [10:0] s1_e_q;
  logic [55:0] s1_mb_q, s1_al_q;

  always_ff @(posedge clk_i) begin
    s1_nan_q  <= a_nan | b_nan | (a_inf & b_inf & (a_i[63] ^ b_i[63]));
    s1_inf_q  <= a_inf | b_inf;
    s1_infs_q <= a_inf ? a_i[63] : b_i[63];
    s1_sign_q <= big[63];
    // An exact zero from opposite signs is +0 under round to nearest.
    s1_zs_q   <= a_i[63] & b_i[63];
    s1_sub_q  <= a_i[63] ^ b_i[63];
    s1_e_q    <= eb;
    s1_mb_q   <= mb;
    s1_al_q   <= {al[55:1], al[0] | st};
  end

  // Stage 2: magnitude add or subtract.
  logic        s2_nan_q, s2_inf_q, s2_infs_q, s2_sign_q, s2_zs_q;
  logic [10:0] s2_e_q;
  logic [56:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    s2_nan_q  <= s1_nan_q;
    s2_inf_q  <= s1_inf_q;
    s2_infs_q <= s1_infs_q;
    s2_sign_q <= s1_sign_q;
    s2_zs_q   <= s1_zs_q;
    s2_e_q    <= s1_e_q;
    s2_sum_q  <= s1_sub_q ? ({1'b0, s1_mb_q} - {1'b0, s1_al_q})
                          : ({1'b0, s1_mb_q} + {1'b0, s1_al_q});
  end

  // Stage 3: leading zero count and normalization amount.
  logic [6:0]  lz, lzp, sh_d;
  logic [11:0] em1;
  logic [12:0] en_d;
  logic        right_d;

  always_comb begin
    lz      = lzc106({s2_sum_q, 49'd0});
    lzp     = lz - 7'd1;
    em1     = {1'b0, s2_e_q} - 12'd1;
    right_d = s2_sum_q[56];
    sh_d    = 7'd0;
    en_d    = {2'b0, s2_e_q} + 13'd1;
    if (!right_d) begin
      sh_d = ({5'd0, lzp} < em1) ? lzp : em1[6:0];
      en_d = {2'b0, s2_e_q} - {6'd0, sh_d};
    end
  end

  logic        s3_nan_q, s3_inf_q, s3_infs_q, s3_sign_q, s3_right_q;
  logic [6:0]  s3_sh_q;
  logic [12:0] s3_en_q;
  logic [56:0] s3_sum_q;

  always_ff @(posedge clk_i) begin
    s3_nan_q   <= s2_nan_q;
    s3_inf_q   <= s2_inf_q;
    s3_infs_q  <= s2_infs_q;
    s3_sign_q  <= (s2_sum_q == 57'd0) ? s2_zs_q : s2_sign_q;
    s3_right_q <= right_d;
    s3_sh_q    <= sh_d;
    s3_en_q    <= en_d;
    s3_sum_q   <= s2_sum_q;
  end

  // Stage 4: normalize, round and pack.
  logic [55:0] m;
  logic [63:0] res_d;

  always_comb begin
    if (s3_right_q) begin
      m = {s3_sum_q[56:2], |s3_sum_q[1:0]};
    end else begin
      m = s3_sum_q[55:0] << s3_sh_q;
    end
    if (s3_nan_q) begin
      res_d = CANON_NAN;
    end else if (s3_inf_q) begin
      res_d = {s3_infs_q, EXP_MAX, 52'd0};
    end else begin
      res_d = round_pack(s3_sign_q, s3_en_q, m);
    end
  end

  always_ff @(posedge clk_i) begin
    s_o <= res_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/dpa_accum.sv
// ----------------------------------------------------------------------------
// dpa_accum
// Block sum queue, running-sum accumulator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpa_accum
  import dpa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      blk_valid_i,
  input  wire blk_t      blk_i,
  output logic           pop_o,
  dpa_out_if.source      out_o
);

  localparam int unsigned PW = $clog2(SQ_DEPTH);
  localparam int unsigned CW = $clog2(SQ_DEPTH + 1);

  blk_t                 mem_q [SQ_DEPTH];
  logic [PW-1:0]        wp_q, rp_q;
  logic [CW-1:0]        fcnt_q;
  logic [FADD_LAT-1:0]  apv_q;
  logic                 busy;
  logic                 pop;
  logic                 done;
  logic                 cur_last_q;
  logic                 started_q;
  logic [63:0]          sum_q;
  logic [63:0]          acc_b;
  logic [63:0]          acc_s;
  logic                 ovalid_q;
  logic [63:0]          odata_q;

  assign busy  = |apv_q;
  assign done  = apv_q[FADD_LAT-1];
  assign pop   = (fcnt_q != '0) && !busy && (!ovalid_q || out_o.ready);
  assign pop_o = pop;
  // Adding -0 leaves any value unchanged, so the first block just loads.
  assign acc_b = started_q ? sum_q : NEG_ZERO;

  dpa_fadd u_acc_add (
    .clk_i (clk_i),
    .a_i   (mem_q[rp_q].sum),
    .b_i   (acc_b),
    .s_o   (acc_s)
  );

  always_ff @(posedge clk_i) begin
    if (blk_valid_i) begin
      mem_q[wp_q] <= blk_i;
    end
    if (pop) begin
      cur_last_q <= mem_q[rp_q].last;
    end
    if (done && cur_last_q) begin
      odata_q <= acc_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      fcnt_q    <= '0;
      apv_q     <= '0;
      started_q <= 1'b0;
      sum_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (blk_valid_i) begin
        wp_q <= wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + PW'(1);
      end
      fcnt_q <= fcnt_q + CW'(blk_valid_i) - CW'(pop);
      apv_q  <= {apv_q[FADD_LAT-2:0], pop};
      if (done) begin
        if (cur_last_q) begin
          started_q <= 1'b0;
          sum_q     <= '0;
        end else begin
          started_q <= 1'b1;
          sum_q     <= acc_s;
        end
      end
      if (done && cur_last_q) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.dot_result = odata_q;

endmodule

`default_nettype wire

>>> hw/rtl/fp64_dot_product_accumulator_unit.sv
// Path from an accepted item to its result: multiply, two levels of block-sum add, queue,
// accumulate add and output register, when nothing waits in the queue.
// Flow: the four-stage accumulate adder loop takes a new block sum only once it is idle;
// up to 4 items are taken back to back into the lane pipeline and block-sum queue.
// Reset: asynchronous, active low; clears the running sum, queue and valid flags.
// ----------------------------------------------------------------------------
// fp64_dot_product_accumulator_unit
// Four multiplier lanes, a two-level adder tree and a running-sum accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module fp64_dot_product_accumulator_unit
  import dpa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dpa_in_if.sink    in_i,
  dpa_out_if.source out_o
);

  localparam int unsigned CW = $clog2(SQ_DEPTH + 1);

  logic [63:0]         xv [LANES];
  logic [63:0]         yv [LANES];
  logic [63:0]         pv [LANES];
  logic [63:0]         lo_s, hi_s, blk_s;
  logic [PIPE_LAT-1:0] vld_q;
  logic [PIPE_LAT-1:0] last_q;
  logic [CW-1:0]       cred_q;
  logic                accept;
  logic                pop;
  blk_t                blk;

  always_comb begin
    xv[0] = in_i.x_lane0;
    xv[1] = in_i.x_lane1;
    xv[2] = in_i.x_lane2;
    xv[3] = in_i.x_lane3;
    yv[0] = in_i.y_lane0;
    yv[1] = in_i.y_lane1;
    yv[2] = in_i.y_lane2;
    yv[3] = in_i.y_lane3;
  end

  // Items in flight plus queued never exceed the queue depth.
  assign in_i.ready = cred_q < CW'(SQ_DEPTH);
  assign accept     = in_i.valid && in_i.ready;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    dpa_fmul u_mul (
      .clk_i (clk_i),
      .a_i   (xv[g]),
      .b_i   (yv[g]),
      .p_o   (pv[g])
    );
  end

  dpa_fadd u_add_lo (.clk_i(clk_i), .a_i(pv[0]), .b_i(pv[1]), .s_o(lo_s));
  dpa_fadd u_add_hi (.clk_i(clk_i), .a_i(pv[2]), .b_i(pv[3]), .s_o(hi_s));
  dpa_fadd u_add_blk (.clk_i(clk_i), .a_i(lo_s), .b_i(hi_s), .s_o(blk_s));

  always_ff @(posedge clk_i) begin
    last_q <= {last_q[PIPE_LAT-2:0], in_i.last_block};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      cred_q <= '0;
    end else begin
      vld_q  <= {vld_q[PIPE_LAT-2:0], accept};
      cred_q <= cred_q + CW'(accept) - CW'(pop);
    end
  end

  assign blk.last = last_q[PIPE_LAT-1];
  assign blk.sum  = blk_s;

  dpa_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (vld_q[PIPE_LAT-1]),
    .blk_i       (blk),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
